@@ rtl/core/fhne_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the frequency heap emitter.
// No dependencies.
package fhne_pkg;
  localparam int unsigned HeapDepthDef  = 256;
  localparam int unsigned CountWidthDef = 16;
  localparam int unsigned SymW = 8;

  localparam logic [1:0] StCounted  = 2'd0;
  localparam logic [1:0] StEmitted  = 2'd1;
  localparam logic [1:0] StNotPoss  = 2'd2;

  localparam logic OpAdd  = 1'b0;
  localparam logic OpEmit = 1'b1;

  // Read address selects relative to the current position p.
  localparam logic [1:0] RdP   = 2'd0;
  localparam logic [1:0] RdPar = 2'd1;
  localparam logic [1:0] RdLft = 2'd2;
  localparam logic [1:0] RdRgt = 2'd3;

  // Datapath commands from the controller.
  typedef struct packed {
    logic load;        // capture the incoming word, p <= 1, scan pointer <= 1
    logic scan_rd;     // read at the scan pointer and advance it
    logic rd;          // read memory at the rd_sel address
    logic [1:0] rd_sel;
    logic set_found;   // p <= position of the entry just checked
    logic set_p2;
    logic set_p3;
    logic move_up;     // p <= parent
    logic move_l;      // p <= left child
    logic move_r;      // p <= right child
    logic wr_new;      // append a new entry with count 1
    logic wr_cur;      // write the current entry at p
    logic wr_a;        // write operand a at p
    logic wr_rd;       // write the read data at p
    logic cap_rd;      // current entry <= read data
    logic cap_rd_inc;  // current entry <= read data with its count raised
    logic cap_a_cur;   // current entry <= operand a
    logic cap_a;       // operand a <= read data
    logic dec_cnt;
    logic mark_last;
    logic res_set;
    logic [1:0] res_status;
  } fhne_cmd_t;

  typedef struct packed {
    logic scan_hit;
    logic scan_end;
    logic full;
    logic empty;
    logic root_rep;    // read symbol equals last emitted
    logic cnt_ge3;
    logic cnt_eq2;
    logic cur_zero;
    logic p_is_root;
    logic rd_lt_cur;
    logic has_l;
    logic has_r;
    logic a_gt_rd;
    logic a_gt_cur;
    logic rd_gt_a;
    logic rd_gt_cur;
  } fhne_sts_t;
endpackage

@@ rtl/core/fhne_datapath.sv @@
`timescale 1ns / 1ps
// Heap memory, entry registers and compares for the frequency heap emitter.
// Depends on fhne_pkg.
module fhne_datapath #(
  parameter int unsigned HEAP_DEPTH  = fhne_pkg::HeapDepthDef,
  parameter int unsigned COUNT_WIDTH = fhne_pkg::CountWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fhne_pkg::fhne_cmd_t cmd_i,
  output fhne_pkg::fhne_sts_t sts_o,
  input  logic [7:0]          symbol_i,
  output logic [1:0]          status_o,
  output logic [7:0]          symbol_out_o
);
  import fhne_pkg::*;
  localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int unsigned PW = $clog2(HEAP_DEPTH + 2) + 1;
  localparam int unsigned EW = SymW + COUNT_WIDTH;
  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};

  logic [EW-1:0] mem_q [HEAP_DEPTH];
  logic [EW-1:0] rdat_q;
  logic [PW-1:0] cnt_q, cnt_d, scan_q, scan_d, p_q, p_d, chk_pos_q;
  logic          chk_v_q;
  logic [7:0]    sym_q, last_q;
  logic          last_v_q;
  logic [EW-1:0] cur_q, a_q;
  logic [1:0]    st_q;
  logic [7:0]    so_q;
  logic [PW-1:0] rd_pos, par, lft, rgt, wpos;
  logic [EW-1:0] wdat;
  logic          wen, ren;
  logic [7:0]    rd_sym, cur_sym;
  logic [COUNT_WIDTH-1:0] rd_cnt, cur_cnt, a_cnt, rd_inc;

  assign par = p_q >> 1;
  assign lft = p_q << 1;
  assign rgt = (p_q << 1) | PW'(1);

  assign rd_sym  = rdat_q[EW-1 -: SymW];
  assign rd_cnt  = rdat_q[COUNT_WIDTH-1:0];
  assign cur_sym = cur_q[EW-1 -: SymW];
  assign cur_cnt = cur_q[COUNT_WIDTH-1:0];
  assign a_cnt   = a_q[COUNT_WIDTH-1:0];
  assign rd_inc  = (rd_cnt == CntMax) ? rd_cnt : rd_cnt + COUNT_WIDTH'(1);

  // Memory positions are 1-based.
  always_comb begin
    case (cmd_i.rd_sel)
      RdP:     rd_pos = p_q;
      RdPar:   rd_pos = par;
      RdLft:   rd_pos = lft;
      RdRgt:   rd_pos = rgt;
      default: rd_pos = p_q;
    endcase
    if (cmd_i.scan_rd) rd_pos = scan_q;
  end

  assign ren = cmd_i.rd | cmd_i.scan_rd;

  always_comb begin
    wen  = 1'b0;
    wpos = p_q;
    wdat = cur_q;
    if (cmd_i.wr_new) begin
      wen = 1'b1; wpos = cnt_q + PW'(1); wdat = {sym_q, COUNT_WIDTH'(1)};
    end else if (cmd_i.wr_cur) begin
      wen = 1'b1;
    end else if (cmd_i.wr_a) begin
      wen = 1'b1; wdat = a_q;
    end else if (cmd_i.wr_rd) begin
      wen = 1'b1; wdat = rdat_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wen) mem_q[AW'(wpos - PW'(1))] <= wdat;
    if (ren) rdat_q <= mem_q[AW'(rd_pos - PW'(1))];
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.wr_new) cnt_d = cnt_q + PW'(1);
    scan_d = scan_q;
    if (cmd_i.load) scan_d = PW'(1);
    else if (cmd_i.scan_rd) scan_d = scan_q + PW'(1);
    p_d = p_q;
    if (cmd_i.load) p_d = PW'(1);
    else if (cmd_i.set_found) p_d = chk_pos_q;
    else if (cmd_i.set_p2) p_d = PW'(2);
    else if (cmd_i.set_p3) p_d = PW'(3);
    else if (cmd_i.move_up) p_d = par;
    else if (cmd_i.move_l) p_d = lft;
    else if (cmd_i.move_r) p_d = rgt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; last_q <= '0; last_v_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.mark_last) begin
        last_q <= cur_sym; last_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q  <= scan_d;
    p_q     <= p_d;
    // The search reads one entry per cycle and checks it in the cycle after.
    chk_v_q <= cmd_i.scan_rd;
    if (cmd_i.scan_rd) chk_pos_q <= scan_q;
    if (cmd_i.load) sym_q <= symbol_i;
    if (cmd_i.cap_rd) cur_q <= rdat_q;
    else if (cmd_i.cap_rd_inc) cur_q <= {rd_sym, rd_inc};
    else if (cmd_i.cap_a_cur) cur_q <= a_q;
    else if (cmd_i.dec_cnt) cur_q[COUNT_WIDTH-1:0] <= cur_cnt - COUNT_WIDTH'(1);
    if (cmd_i.cap_a) a_q <= rdat_q;
    if (cmd_i.res_set) begin
      st_q <= cmd_i.res_status;
      case (cmd_i.res_status)
        StCounted: so_q <= sym_q;
        StEmitted: so_q <= cur_sym;
        default:   so_q <= '0;
      endcase
    end
  end

  assign status_o     = st_q;
  assign symbol_out_o = so_q;

  assign sts_o.scan_hit  = chk_v_q && (rd_sym == sym_q);
  assign sts_o.scan_end  = scan_q > cnt_q;
  assign sts_o.full      = cnt_q >= PW'(HEAP_DEPTH);
  assign sts_o.empty     = cnt_q == '0;
  assign sts_o.root_rep  = last_v_q && (rd_sym == last_q);
  assign sts_o.cnt_ge3   = cnt_q >= PW'(3);
  assign sts_o.cnt_eq2   = cnt_q == PW'(2);
  assign sts_o.cur_zero  = cur_cnt == '0;
  assign sts_o.p_is_root = p_q == PW'(1);
  assign sts_o.rd_lt_cur = rd_cnt < cur_cnt;
  assign sts_o.has_l     = lft <= cnt_q;
  assign sts_o.has_r     = rgt <= cnt_q;
  assign sts_o.a_gt_rd   = a_cnt > rd_cnt;
  assign sts_o.a_gt_cur  = a_cnt > cur_cnt;
  assign sts_o.rd_gt_a   = rd_cnt > a_cnt;
  assign sts_o.rd_gt_cur = rd_cnt > cur_cnt;
endmodule

@@ rtl/core/fhne_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for search, sift-up, emit choice and sift-down.
// Depends on fhne_pkg.
module fhne_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  logic                op_i,
  output logic                valid_o,
  input  logic                stall_i,
  output fhne_pkg::fhne_cmd_t cmd_o,
  input  fhne_pkg::fhne_sts_t sts_i
);
  import fhne_pkg::*;
  localparam logic [3:0] SIdle    = 4'd0,  SScan   = 4'd1,  SUpRd  = 4'd2,
                         SUpCmp   = 4'd3,  SEmStart = 4'd4, SEmRoot = 4'd5,
                         SEmL     = 4'd6,  SEmR    = 4'd7,  SEmCap = 4'd8,
                         SPick    = 4'd9,  SDnRd   = 4'd10, SDnL   = 4'd11,
                         SDnR     = 4'd12;
  logic [3:0] st_q, st_d;
  logic       vo_q, vo_d;

  always_comb begin
    logic fin;
    logic take_r;
    fin = 1'b0;
    take_r = 1'b0;
    cmd_o = '0;
    st_d = st_q;
    vo_d = vo_q;
    if (vo_q && !stall_i) vo_d = 1'b0;
    case (st_q)
      SIdle: begin
        if (valid_i && !vo_q) begin
          cmd_o.load = 1'b1;
          st_d = (op_i == OpAdd) ? SScan : SEmStart;
        end
      end
      SScan: begin
        if (sts_i.scan_hit) begin
          cmd_o.set_found = 1'b1; cmd_o.cap_rd_inc = 1'b1; st_d = SUpRd;
        end else if (!sts_i.scan_end) begin
          cmd_o.scan_rd = 1'b1;
        end else if (sts_i.full) begin
          cmd_o.res_set = 1'b1; cmd_o.res_status = StNotPoss; fin = 1'b1;
        end else begin
          cmd_o.wr_new = 1'b1;
          cmd_o.res_set = 1'b1; cmd_o.res_status = StCounted; fin = 1'b1;
        end
      end
      SUpRd: begin
        if (sts_i.p_is_root) begin
          cmd_o.wr_cur = 1'b1;
          cmd_o.res_set = 1'b1; cmd_o.res_status = StCounted; fin = 1'b1;
        end else begin
          cmd_o.rd = 1'b1; cmd_o.rd_sel = RdPar; st_d = SUpCmp;
        end
      end
      SUpCmp: begin
        if (sts_i.rd_lt_cur) begin
          // Parent moves down into p, the current entry moves up.
          cmd_o.wr_rd = 1'b1; cmd_o.move_up = 1'b1; st_d = SUpRd;
        end else begin
          cmd_o.wr_cur = 1'b1;
          cmd_o.res_set = 1'b1; cmd_o.res_status = StCounted; fin = 1'b1;
        end
      end
      SEmStart: begin
        if (sts_i.empty) begin
          cmd_o.res_set = 1'b1; cmd_o.res_status = StNotPoss; fin = 1'b1;
        end else begin
          cmd_o.rd = 1'b1; cmd_o.rd_sel = RdP; st_d = SEmRoot;
        end
      end
      SEmRoot: begin
        if (!sts_i.root_rep) begin
          cmd_o.cap_rd = 1'b1; st_d = SPick;
        end else if (sts_i.cnt_ge3) begin
          cmd_o.rd = 1'b1; cmd_o.rd_sel = RdLft; st_d = SEmL;
        end else if (sts_i.cnt_eq2) begin
          cmd_o.rd = 1'b1; cmd_o.rd_sel = RdLft; cmd_o.set_p2 = 1'b1; st_d = SEmCap;
        end else begin
          cmd_o.res_set = 1'b1; cmd_o.res_status = StNotPoss; fin = 1'b1;
        end
      end
      SEmL: begin
        cmd_o.cap_a = 1'b1; cmd_o.rd = 1'b1; cmd_o.rd_sel = RdRgt; st_d = SEmR;
      end
      SEmR: begin
        // Position 2 wins only when its count is strictly greater.
        if (sts_i.a_gt_rd) begin
          cmd_o.cap_a_cur = 1'b1; cmd_o.set_p2 = 1'b1;
        end else begin
          cmd_o.cap_rd = 1'b1; cmd_o.set_p3 = 1'b1;
        end
        st_d = SPick;
      end
      SEmCap: begin
        cmd_o.cap_rd = 1'b1; st_d = SPick;
      end
      SPick: begin
        if (sts_i.cur_zero) begin
          cmd_o.res_set = 1'b1; cmd_o.res_status = StNotPoss; fin = 1'b1;
        end else begin
          cmd_o.dec_cnt = 1'b1; cmd_o.mark_last = 1'b1;
          cmd_o.res_set = 1'b1; cmd_o.res_status = StEmitted;
          st_d = SDnRd;
        end
      end
      SDnRd: begin
        if (sts_i.has_l) begin
          cmd_o.rd = 1'b1; cmd_o.rd_sel = RdLft; st_d = SDnL;
        end else begin
          cmd_o.wr_cur = 1'b1; fin = 1'b1;
        end
      end
      SDnL: begin
        cmd_o.cap_a = 1'b1;
        if (sts_i.has_r) begin
          cmd_o.rd = 1'b1; cmd_o.rd_sel = RdRgt;
        end
        st_d = SDnR;
      end
      SDnR: begin
        take_r = sts_i.has_r && (sts_i.a_gt_cur ? sts_i.rd_gt_a : sts_i.rd_gt_cur);
        if (take_r) begin
          cmd_o.wr_rd = 1'b1; cmd_o.move_r = 1'b1; st_d = SDnRd;
        end else if (sts_i.a_gt_cur) begin
          cmd_o.wr_a = 1'b1; cmd_o.move_l = 1'b1; st_d = SDnRd;
        end else begin
          cmd_o.wr_cur = 1'b1; fin = 1'b1;
        end
      end
      default: st_d = SIdle;
    endcase
    if (fin) begin
      vo_d = 1'b1;
      st_d = SIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; vo_q <= 1'b0;
    end else begin
      st_q <= st_d; vo_q <= vo_d;
    end
  end

  assign stall_o = (st_q != SIdle) || vo_q;
  assign valid_o = vo_q;
endmodule

@@ rtl/core/frequency_heap_no_repeat_emitter.sv @@
`timescale 1ns / 1ps
// Frequency heap emitter: counts byte symbols in a max-heap held in one
// memory and emits symbols so that none repeats back to back. One word in,
// one word out, and only one word is in work at a time; the input is stalled
// from acceptance until the result has been taken. An add searches the live
// entries at one entry per cycle, then sifts up one level at a time, reading
// the parent and then comparing it. An emit reads the root, and if needed its
// children, to pick its entry, then sifts down one level at a time. Dropped
// adds and refused emits end right after the search or the choice.
module frequency_heap_no_repeat_emitter #(
  parameter int unsigned HEAP_DEPTH  = fhne_pkg::HeapDepthDef,
  parameter int unsigned COUNT_WIDTH = fhne_pkg::CountWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic       op_i,
  input  logic [7:0] symbol_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [1:0] status_o,
  output logic [7:0] symbol_out_o
);
  import fhne_pkg::*;
  fhne_cmd_t cmd;
  fhne_sts_t sts;

  fhne_ctrl u_ctrl (
    .clk_i, .rst_ni, .valid_i, .stall_o, .op_i, .valid_o, .stall_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  fhne_datapath #(.HEAP_DEPTH(HEAP_DEPTH), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .symbol_i,
    .status_o, .symbol_out_o
  );
endmodule

@@ rtl/core/fhne_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the frequency heap emitter, bound to the top level.
// Depends on fhne_pkg and the top level's ports.
module fhne_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       valid_i,
  input logic       stall_o,
  input logic       valid_o,
  input logic       stall_i,
  input logic [1:0] status_o,
  input logic [7:0] symbol_out_o
);
  import fhne_pkg::*;
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o == StCounted || status_o == StEmitted ||
                 status_o == StNotPoss)) else $error("bad status");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> stall_o) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(symbol_out_o))
    else $error("result dropped");
  a_np: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && status_o == StNotPoss |-> symbol_out_o == 8'd0)
    else $error("not possible carries symbol");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o |=> stall_o) else $error("second word taken while busy");
endmodule

bind frequency_heap_no_repeat_emitter fhne_checker u_fhne_checker (
  .clk_i, .rst_ni, .valid_i, .stall_o, .valid_o, .stall_i, .status_o, .symbol_out_o
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for the frequency heap emitter: sends add and emit words and
// checks every result against a behavioral max-heap kept in the testbench.
// Depends on fhne_pkg and frequency_heap_no_repeat_emitter.
module testbench;
  import fhne_pkg::*;

  localparam int unsigned Depth = HeapDepthDef;
  localparam int unsigned CntW = CountWidthDef;
  localparam logic [CntW-1:0] CntMax = '1;
  localparam int unsigned IdleLimit = 20000;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] sym;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic op_i = OpAdd;
  logic [7:0] symbol_i = '0;
  logic stall_i = 1'b0;
  logic stall_o, valid_o;
  logic [1:0] status_o;
  logic [7:0] symbol_out_o;

  frequency_heap_no_repeat_emitter u_top (
    .clk_i, .rst_ni, .valid_i, .stall_o, .op_i, .symbol_i,
    .valid_o, .stall_i, .status_o, .symbol_out_o
  );

  always #1 clk_i = ~clk_i;

  // Heap image, 1-based positions.
  logic [7:0] heap_sym [1:Depth];
  logic [CntW-1:0] heap_cnt [1:Depth];
  int unsigned heap_size = 0;
  logic [7:0] last_sym = '0;
  logic last_ok = 1'b0;

  result_t expected_q[$];
  bit failed = 1'b0;
  bit hold_long = 1'b0;
  bit gap_mode = 1'b1;
  int unsigned idle_cycles = 0;

  function automatic void swap_entries(int unsigned a, int unsigned b);
    logic [7:0] s;
    logic [CntW-1:0] c;
    s = heap_sym[a]; c = heap_cnt[a];
    heap_sym[a] = heap_sym[b]; heap_cnt[a] = heap_cnt[b];
    heap_sym[b] = s; heap_cnt[b] = c;
  endfunction

  function automatic result_t heap_step(logic op, logic [7:0] sym);
    result_t r;
    int unsigned p, found, best;
    r.status = StNotPoss;
    r.sym = '0;
    if (op == OpAdd) begin
      found = 0;
      for (p = 1; p <= heap_size; p++) begin
        if (heap_sym[p] == sym) begin
          found = p;
          break;
        end
      end
      if (found == 0) begin
        if (heap_size >= Depth) return r;
        heap_size++;
        heap_sym[heap_size] = sym;
        heap_cnt[heap_size] = CntW'(1);
      end else begin
        if (heap_cnt[found] != CntMax) heap_cnt[found]++;
        p = found;
        while (p > 1 && heap_cnt[p/2] < heap_cnt[p]) begin
          swap_entries(p, p/2);
          p = p / 2;
        end
      end
      r.status = StCounted;
      r.sym = sym;
      return r;
    end
    if (heap_size == 0) return r;
    if (!last_ok || heap_sym[1] != last_sym) p = 1;
    else if (heap_size >= 3) p = (heap_cnt[2] > heap_cnt[3]) ? 2 : 3;
    else if (heap_size == 2) p = 2;
    else return r;
    if (heap_cnt[p] == 0) return r;
    heap_cnt[p]--;
    r.sym = heap_sym[p];
    forever begin
      best = p;
      if (2*p <= heap_size && heap_cnt[2*p] > heap_cnt[best]) best = 2*p;
      if (2*p+1 <= heap_size && heap_cnt[2*p+1] > heap_cnt[best]) best = 2*p+1;
      if (best == p) break;
      swap_entries(p, best);
      p = best;
    end
    last_sym = r.sym;
    last_ok = 1'b1;
    r.status = StEmitted;
    return r;
  endfunction

  // Sends one word; the sender idles between bursts when gap_mode is set.
  int unsigned burst_left = 0;
  task automatic send_word(logic op, logic [7:0] sym);
    if (gap_mode && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    if (burst_left != 0) burst_left--;
    valid_i <= 1'b1;
    op_i <= op;
    symbol_i <= sym;
    do @(posedge clk_i); while (stall_o);
    expected_q.push_back(heap_step(op, sym));
    valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stall pattern, or a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_long) stall_i <= 1'b1;
    else stall_i <= ($urandom_range(0, 3) == 0) && ($time % 400 < 250);
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (valid_o && !stall_i) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word status=%0d sym=%0d", $time, status_o,
                 symbol_out_o);
        failed = 1'b1;
      end else begin
        exp_r = expected_q.pop_front();
        if (status_o !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status_o);
          failed = 1'b1;
        end
        if (symbol_out_o !== exp_r.sym) begin
          $display("%0t: symbol expected %0d actual %0d", $time, exp_r.sym, symbol_out_o);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_empty_and_repeat();
    send_word(OpEmit, 8'h00);
    send_word(OpAdd, 8'h00);
    send_word(OpEmit, 8'h00);
    send_word(OpEmit, 8'h00);   // only one entry and it repeats
    send_word(OpAdd, 8'hFF);
    send_word(OpAdd, 8'h00);
    send_word(OpEmit, 8'h00);
    send_word(OpEmit, 8'h00);   // the root no longer repeats and is taken
    send_word(OpAdd, 8'hAA);
    send_word(OpAdd, 8'h55);
    repeat (6) send_word(OpEmit, 8'h00);
    send_word(OpEmit, 8'hFF);   // zero counts remain in the heap
    send_word(OpAdd, 8'hFF);
    send_word(OpEmit, 8'h00);
  endtask

  // Symbols drawn from an alphabet of alpha values with emits mixed in.
  task automatic test_random_mix(int unsigned n, int unsigned alpha);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0) send_word(OpEmit, 8'($urandom));
      else send_word(OpAdd, 8'($urandom_range(0, alpha - 1)));
    end
  endtask

  task automatic test_backpressure();
    hold_long = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_long = 1'b0;
      end
      test_random_mix(20, 8);
    join
    wait_drained();
  endtask

  // Fill every position; with all byte values present, later adds search a
  // full heap and always find their entry.
  task automatic test_full_heap();
    gap_mode = 1'b0;
    for (int unsigned s = 0; s < 256; s++) send_word(OpAdd, 8'(s));
    test_random_mix(40, 256);
    gap_mode = 1'b1;
  endtask

  // One symbol counted many times, then emitted around its own repeats.
  task automatic test_repeated_symbol();
    gap_mode = 1'b0;
    repeat (24) send_word(OpAdd, 8'h3C);
    repeat (6) send_word(OpEmit, 8'h00);
    send_word(OpAdd, 8'h3C);
    gap_mode = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_repeat();
    test_backpressure();
    test_random_mix(440, 6);
    wait_drained();
    test_random_mix(440, 24);
    test_full_heap();
    wait_drained();
    test_repeated_symbol();
    wait_drained();
    repeat (600) @(posedge clk_i);
    if (!failed && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
